>>> rtl/dpm_pkg.sv
package dpm_pkg;

  localparam int VIRT_PAGES  = 2048;
  localparam int FRAMES      = 8;
  localparam int OFFSET_BITS = 2;
  localparam int SWAP_SLOTS  = 128;

  localparam int ADDR_W  = 13;
  localparam int PHYS_W  = 5;
  localparam int VPN_W   = $clog2(VIRT_PAGES);
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int NFF_W   = $clog2(FRAMES + 1);
  localparam int SLOT_W  = $clog2(SWAP_SLOTS);
  localparam int NSS_W   = $clog2(SWAP_SLOTS + 1);
  localparam int WHERE_W = (SLOT_W > FRAME_W) ? SLOT_W : FRAME_W;

  typedef struct packed {
    logic [WHERE_W-1:0] where;
    logic               resident;
    logic               on_swap;
    logic               modified;
    logic               referenced;
  } page_entry_t;

  localparam int PE_W = $bits(page_entry_t);

  typedef struct packed {
    logic              has_owner;
    logic [VPN_W-1:0]  owner;
    logic [SLOT_W-1:0] slot;
  } frame_entry_t;

  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] idx;
    frame_entry_t       data;
  } frame_wr_t;

  typedef struct packed {
    logic [PHYS_W-1:0] paddr;
    logic              fault;
    logic              write_back;
    logic [SLOT_W-1:0] write_slot;
    logic              read_in;
    logic [SLOT_W-1:0] read_slot;
    logic              zero_fill;
    logic              swap_full;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CLK_CHECK,
    ST_CLK_READ,
    ST_VICTIM,
    ST_VICTIM_READ,
    ST_INSTALL,
    ST_FINISH
  } state_e;

endpackage

>>> rtl/dpm_ram.sv
module dpm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/dpm_frame_tbl.sv
module dpm_frame_tbl
  import dpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frame_wr_t          wr_i,
  input  logic [FRAME_W-1:0] rd_idx_i,
  output frame_entry_t       rd_data_o
);

  frame_entry_t ent_q [FRAMES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        ent_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      ent_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = ent_q[rd_idx_i];

endmodule

>>> rtl/dpm_ctrl.sv
module dpm_ctrl
  import dpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] virt_addr_i,
  input  logic              is_write_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  state_e state_q, state_d;
  logic [VPN_W-1:0]       vpn_q, vpn_d, clr_q, clr_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic                   wr_q, wr_d;
  page_entry_t            pe_q, pe_d;
  frame_entry_t           fe_q, fe_d;
  logic [FRAME_W-1:0]     frame_q, frame_d, cur_q, cur_d;
  logic [FRAME_W-1:0]     fifo_q, fifo_d, clock_q, clock_d;
  logic [NFF_W-1:0]       nff_q, nff_d;
  logic [NSS_W-1:0]       nss_q, nss_d;
  result_t                res_q, res_d;

  logic               pt_we;
  logic [VPN_W-1:0]   pt_waddr, pt_raddr;
  page_entry_t        pt_wdata, pt_rdata, ent;
  logic [PE_W-1:0]    pt_rdata_raw;
  frame_wr_t          ft_wr;
  logic [FRAME_W-1:0] ft_rd_idx;
  frame_entry_t       ft_rd_data;
  logic [SLOT_W-1:0]  slot;

  function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] f);
    return (f == FRAME_W'(FRAMES - 1)) ? '0 : f + 1'b1;
  endfunction

  dpm_ram #(.WIDTH(PE_W), .DEPTH(VIRT_PAGES)) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (pt_we),
    .waddr_i(pt_waddr),
    .wdata_i(pt_wdata),
    .raddr_i(pt_raddr),
    .rdata_o(pt_rdata_raw)
  );
  assign pt_rdata = page_entry_t'(pt_rdata_raw);

  dpm_frame_tbl u_frame_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (ft_wr),
    .rd_idx_i (ft_rd_idx),
    .rd_data_o(ft_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      nff_q   <= '0;
      nss_q   <= '0;
      fifo_q  <= '0;
      clock_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nff_q   <= nff_d;
      nss_q   <= nss_d;
      fifo_q  <= fifo_d;
      clock_q <= clock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vpn_q   <= vpn_d;
    off_q   <= off_d;
    wr_q    <= wr_d;
    pe_q    <= pe_d;
    fe_q    <= fe_d;
    frame_q <= frame_d;
    cur_q   <= cur_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    vpn_d     = vpn_q;
    off_d     = off_q;
    wr_d      = wr_q;
    pe_d      = pe_q;
    fe_d      = fe_q;
    frame_d   = frame_q;
    cur_d     = cur_q;
    fifo_d    = fifo_q;
    clock_d   = clock_q;
    nff_d     = nff_q;
    nss_d     = nss_q;
    res_d     = res_q;
    pt_we     = 1'b0;
    pt_waddr  = vpn_q;
    pt_wdata  = '0;
    pt_raddr  = vpn_q;
    ft_wr     = '0;
    ft_rd_idx = frame_q;
    ent       = pt_rdata;
    slot      = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == VPN_W'(VIRT_PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        pt_raddr   = virt_addr_i[OFFSET_BITS +: VPN_W];
        if (in_valid_i) begin
          vpn_d   = virt_addr_i[OFFSET_BITS +: VPN_W];
          off_d   = virt_addr_i[OFFSET_BITS-1:0];
          wr_d    = is_write_i;
          res_d   = '0;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        pe_d = pt_rdata;
        if (pt_rdata.resident) begin
          ent.referenced = 1'b1;
          ent.modified   = pt_rdata.modified | wr_q;
          pt_we          = 1'b1;
          pt_wdata       = ent;
          res_d.paddr    = {pt_rdata.where[FRAME_W-1:0], off_q};
          state_d        = ST_FINISH;
        end else begin
          res_d.fault = 1'b1;
          if (nff_q != NFF_W'(FRAMES)) begin
            frame_d = nff_q[FRAME_W-1:0];
            nff_d   = nff_q + 1'b1;
            state_d = ST_INSTALL;
          end else if (mode_i) begin
            cur_d   = clock_q;
            state_d = ST_CLK_CHECK;
          end else begin
            frame_d = fifo_q;
            fifo_d  = next_frame(fifo_q);
            state_d = ST_VICTIM;
          end
        end
      end
      ST_CLK_CHECK: begin
        ft_rd_idx = cur_q;
        fe_d      = ft_rd_data;
        pt_raddr  = ft_rd_data.owner;
        if (!ft_rd_data.has_owner) begin
          frame_d = cur_q;
          clock_d = next_frame(cur_q);
          state_d = ST_VICTIM;
        end else begin
          state_d = ST_CLK_READ;
        end
      end
      ST_CLK_READ: begin
        if (!pt_rdata.referenced) begin
          frame_d = cur_q;
          clock_d = next_frame(cur_q);
          state_d = ST_VICTIM;
        end else begin
          // Second chance: clear the reference mark and move the hand on.
          ent.referenced = 1'b0;
          pt_we    = 1'b1;
          pt_waddr = fe_q.owner;
          pt_wdata = ent;
          cur_d    = next_frame(cur_q);
          state_d  = ST_CLK_CHECK;
        end
      end
      ST_VICTIM: begin
        fe_d     = ft_rd_data;
        pt_raddr = ft_rd_data.owner;
        state_d  = ft_rd_data.has_owner ? ST_VICTIM_READ : ST_INSTALL;
      end
      ST_VICTIM_READ: begin
        slot = fe_q.slot;
        ent.resident = 1'b0;
        if (pt_rdata.modified) begin
          if (pt_rdata.on_swap) begin
            res_d.write_back = 1'b1;
            res_d.write_slot = slot;
          end else if (nss_q != NSS_W'(SWAP_SLOTS)) begin
            slot = nss_q[SLOT_W-1:0];
            nss_d = nss_q + 1'b1;
            ent.on_swap = 1'b1;
            res_d.write_back = 1'b1;
            res_d.write_slot = slot;
          end else begin
            res_d.swap_full = 1'b1;
          end
        end
        ent.where = WHERE_W'(slot);
        pt_we    = 1'b1;
        pt_waddr = fe_q.owner;
        pt_wdata = ent;
        state_d  = ST_INSTALL;
      end
      ST_INSTALL: begin
        ft_wr.we             = 1'b1;
        ft_wr.idx            = frame_q;
        ft_wr.data.has_owner = 1'b1;
        ft_wr.data.owner     = vpn_q;
        if (pe_q.on_swap) begin
          ft_wr.data.slot = pe_q.where[SLOT_W-1:0];
          res_d.read_in   = 1'b1;
          res_d.read_slot = pe_q.where[SLOT_W-1:0];
        end else begin
          res_d.zero_fill = 1'b1;
        end
        ent.where      = WHERE_W'(frame_q);
        ent.resident   = 1'b1;
        ent.on_swap    = pe_q.on_swap;
        ent.modified   = wr_q;
        ent.referenced = 1'b1;
        pt_we          = 1'b1;
        pt_wdata       = ent;
        res_d.paddr    = {frame_q, off_q};
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

>>> rtl/demand_paging_mmu_core.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    virt_addr_i, is_write_i
// out       output     out_valid_o / out_ready_i  paddr_o, fault_o, write_back_o,
//                                                 write_slot_o, read_in_o, read_slot_o,
//                                                 zero_fill_o, swap_full_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_replace_mode_i
//
// A hit is answered from the lookup; a fault with a free frame installs the page directly;
// a FIFO eviction first reads the victim's frame and page entries; a clock eviction sweeps
// the frame table, reading each owner's entry from the single-read page table memory.
// After reset all VIRT_PAGES page table entries are cleared, one entry a cycle;
// no request is taken meanwhile. A result waits in the output register while the
// next request is already looked up.
module demand_paging_mmu_core
  import dpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_replace_mode_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] virt_addr_i,
  input  logic              is_write_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PHYS_W-1:0] paddr_o,
  output logic              fault_o,
  output logic              write_back_o,
  output logic [SLOT_W-1:0] write_slot_o,
  output logic              read_in_o,
  output logic [SLOT_W-1:0] read_slot_o,
  output logic              zero_fill_o,
  output logic              swap_full_o
);

  logic    mode_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    res_valid, res_ready;

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !out_valid_q || out_ready_i;

  dpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .virt_addr_i(virt_addr_i),
    .is_write_i (is_write_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_replace_mode_i;
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign paddr_o      = out_q.paddr;
  assign fault_o      = out_q.fault;
  assign write_back_o = out_q.write_back;
  assign write_slot_o = out_q.write_slot;
  assign read_in_o    = out_q.read_in;
  assign read_slot_o  = out_q.read_slot;
  assign zero_fill_o  = out_q.zero_fill;
  assign swap_full_o  = out_q.swap_full;

endmodule

>>> rtl/dpm_checker.sv
module dpm_checker
  import dpm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [PHYS_W-1:0] paddr_o,
  input logic              fault_o,
  input logic              write_back_o,
  input logic [SLOT_W-1:0] write_slot_o,
  input logic              read_in_o,
  input logic [SLOT_W-1:0] read_slot_o,
  input logic              zero_fill_o,
  input logic              swap_full_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(paddr_o) && $stable(fault_o))
    else $error("result changed while stalled");

  a_hit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fault_o |-> !write_back_o && !read_in_o && !zero_fill_o &&
      !swap_full_o && write_slot_o == '0 && read_slot_o == '0)
    else $error("hit carries fault actions");

  a_fault_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> read_in_o != zero_fill_o)
    else $error("fault must either read from swap or zero-fill");

  a_wb_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_back_o && swap_full_o) && (write_back_o || write_slot_o == '0))
    else $error("writeback and swap-full disagree");

endmodule

bind demand_paging_mmu_core dpm_checker u_dpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .paddr_o     (paddr_o),
  .fault_o     (fault_o),
  .write_back_o(write_back_o),
  .write_slot_o(write_slot_o),
  .read_in_o   (read_in_o),
  .read_slot_o (read_slot_o),
  .zero_fill_o (zero_fill_o),
  .swap_full_o (swap_full_o)
);

>>> tb/tb.sv
module tb;
  import dpm_pkg::*;

  class mmu_scoreboard;
    result_t   pending[$];
    logic [WHERE_W-1:0] pg_where[VIRT_PAGES];
    bit pg_res[VIRT_PAGES], pg_swap[VIRT_PAGES], pg_mod[VIRT_PAGES], pg_ref[VIRT_PAGES];
    bit                 fr_own[FRAMES];
    logic [VPN_W-1:0]   fr_page[FRAMES];
    logic [SLOT_W-1:0]  fr_slot[FRAMES];
    int  free_frames, fifo_ptr, clock_ptr, swap_used;
    bit  use_clock;
    int  errors, checked, faults, writebacks, fulls;

    function new();
      for (int i = 0; i < VIRT_PAGES; i++) begin
        pg_where[i] = '0; pg_res[i] = 0; pg_swap[i] = 0; pg_mod[i] = 0; pg_ref[i] = 0;
      end
      for (int i = 0; i < FRAMES; i++) begin
        fr_own[i] = 0; fr_page[i] = '0; fr_slot[i] = '0;
      end
      free_frames = 0; fifo_ptr = 0; clock_ptr = 0; swap_used = 0; use_clock = 0;
      errors = 0; checked = 0; faults = 0; writebacks = 0; fulls = 0;
    endfunction

    function int sweep_clock();
      int f;
      f = clock_ptr;
      for (int v = 0; v <= FRAMES; v++) begin
        if (!fr_own[f] || !pg_ref[fr_page[f]]) break;
        pg_ref[fr_page[f]] = 0;
        f = (f + 1) % FRAMES;
      end
      clock_ptr = (f + 1) % FRAMES;
      return f;
    endfunction

    function void note_request(logic [ADDR_W-1:0] addr, logic wr);
      result_t r;
      int vp, frame, slot, victim;
      bit ok;
      vp = (addr >> OFFSET_BITS) % VIRT_PAGES;
      r = '0;
      if (!pg_res[vp]) begin
        r.fault = 1;
        if (free_frames < FRAMES) begin
          frame = free_frames++;
        end else begin
          if (use_clock) frame = sweep_clock();
          else begin
            frame = fifo_ptr;
            fifo_ptr = (fifo_ptr + 1) % FRAMES;
          end
          if (fr_own[frame]) begin
            victim = fr_page[frame];
            slot = fr_slot[frame];
            pg_res[victim] = 0;
            if (pg_mod[victim]) begin
              ok = 1;
              if (!pg_swap[victim]) begin
                if (swap_used < SWAP_SLOTS) begin
                  slot = swap_used++;
                  pg_swap[victim] = 1;
                end else begin
                  ok = 0;
                  r.swap_full = 1;
                end
              end
              if (ok) begin
                r.write_back = 1;
                r.write_slot = SLOT_W'(slot);
              end
            end
            pg_where[victim] = WHERE_W'(slot);
          end
        end
        if (pg_swap[vp]) begin
          fr_slot[frame] = pg_where[vp];
          r.read_in = 1;
          r.read_slot = pg_where[vp];
        end else begin
          fr_slot[frame] = '0;
          r.zero_fill = 1;
        end
        fr_own[frame] = 1;
        fr_page[frame] = VPN_W'(vp);
        pg_where[vp] = WHERE_W'(frame);
        pg_res[vp] = 1;
        pg_mod[vp] = 0;
      end
      pg_ref[vp] = 1;
      if (wr) pg_mod[vp] = 1;
      r.paddr = PHYS_W'((pg_where[vp] << OFFSET_BITS) + (addr & ((1 << OFFSET_BITS) - 1)));
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      faults += w.fault;
      writebacks += w.write_back;
      fulls += w.swap_full;
      if (got.paddr !== w.paddr) begin
        $error("paddr exp %0d got %0d", w.paddr, got.paddr); errors++;
      end
      if (got.fault !== w.fault) begin
        $error("fault exp %0d got %0d", w.fault, got.fault); errors++;
      end
      if (got.write_back !== w.write_back) begin
        $error("write_back exp %0d got %0d", w.write_back, got.write_back); errors++;
      end
      if (got.write_slot !== w.write_slot) begin
        $error("write_slot exp %0d got %0d", w.write_slot, got.write_slot); errors++;
      end
      if (got.read_in !== w.read_in) begin
        $error("read_in exp %0d got %0d", w.read_in, got.read_in); errors++;
      end
      if (got.read_slot !== w.read_slot) begin
        $error("read_slot exp %0d got %0d", w.read_slot, got.read_slot); errors++;
      end
      if (got.zero_fill !== w.zero_fill) begin
        $error("zero_fill exp %0d got %0d", w.zero_fill, got.zero_fill); errors++;
      end
      if (got.swap_full !== w.swap_full) begin
        $error("swap_full exp %0d got %0d", w.swap_full, got.swap_full); errors++;
      end
    endfunction
  endclass

  logic              clk_i, rst_ni;
  logic              cfg_valid_i, cfg_ready_o, cfg_replace_mode_i;
  logic              in_valid_i, in_ready_o;
  logic [ADDR_W-1:0] virt_addr_i;
  logic              is_write_i;
  logic              out_valid_o, out_ready_i;
  result_t           res;

  demand_paging_mmu_core u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_replace_mode_i,
    .in_valid_i, .in_ready_o, .virt_addr_i, .is_write_i,
    .out_valid_o, .out_ready_i,
    .paddr_o(res.paddr), .fault_o(res.fault), .write_back_o(res.write_back),
    .write_slot_o(res.write_slot), .read_in_o(res.read_in), .read_slot_o(res.read_slot),
    .zero_fill_o(res.zero_fill), .swap_full_o(res.swap_full)
  );

  mmu_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct, stall_cycles, sent;
  bit req_taken;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    req_taken = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(virt_addr_i, is_write_i);
        req_taken = 1;
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(res);
        req_taken = 1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.use_clock = cfg_replace_mode_i;
        req_taken = 1;
      end
      stall_cycles = req_taken ? 0 : stall_cycles + 1;
      if (stall_cycles > 2 * VIRT_PAGES + 20000) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // The receiver stalls at random, independent of the sender.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays up after an accepted request until the next one replaces it or an
  // idle cycle drops it, so each falling edge sees at most one update.
  task automatic send_access(logic [ADDR_W-1:0] addr, logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1;
    virt_addr_i <= addr;
    is_write_i  <= wr;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic set_mode(bit mode);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_valid_i        <= 1;
    cfg_replace_mode_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Most accesses stay in a small working set so that hits, second chances and
  // re-reads from swap are common; a few stray pages keep the swap area filling.
  task automatic run_random(int count, int ws_pages);
    int pg;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: send_access(ADDR_W'($urandom), 1'($urandom));
        1: send_access({VPN_W'($urandom_range(VIRT_PAGES - 1)), OFFSET_BITS'($urandom)},
                       1'b1);
        default: begin
          pg = $urandom_range(ws_pages - 1) * 37;
          send_access({VPN_W'(pg), OFFSET_BITS'($urandom)}, $urandom_range(2) == 0);
        end
      endcase
    end
  endtask

  initial begin
    rst_ni = 0; cfg_valid_i = 0; cfg_replace_mode_i = 0; in_valid_i = 0;
    virt_addr_i = '0; is_write_i = 0; out_ready_i = 0;
    send_idle_pct = 0; recv_idle_pct = 0; stall_cycles = 0; sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;

    // Directed: fill all frames, extremes of the address, FIFO eviction, then clock eviction.
    send_access('0, 1'b0);
    send_access('1, 1'b1);
    for (int i = 1; i <= 7; i++) send_access(13'(i * 4 + 1), i[0]);
    send_access('1, 1'b0);
    send_access(13'h1000, 1'b1);
    send_access(13'h0ffe, 1'b0);
    send_access(13'h1555, 1'b1);
    send_access(13'h0aaa, 1'b0);
    set_mode(1'b1);
    for (int i = 0; i < 8; i++) send_access(13'(i * 4), 1'b1);
    send_access(13'h1ffc, 1'b0);
    send_access('0, 1'b0);

    send_idle_pct = 26; recv_idle_pct = 54;
    run_random(200, 12);
    set_mode(1'b0);
    send_idle_pct = 54; recv_idle_pct = 26;
    run_random(200, 12);
    set_mode(1'b1);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(150, 10);
    set_mode(1'b0);
    run_random(50, 12);
    in_valid_i <= 0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("tb: %0d accesses, %0d results checked, %0d faults, %0d writebacks",
             sent, sb.checked, sb.faults, sb.writebacks);
    $display("tb: %0d swap-full events, FIFO and clock modes both exercised", sb.fulls);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
